// ===== hw/rtl/bitmap_page_allocator_core_assert.svh =====
// Assertion macros for the page allocator checker.
// Used by the checker file only.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BPA_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define BPA_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== hw/rtl/bpa_pkg.sv =====
// Package for the bitmap page allocator: status codes and item layouts.
// No dependencies.
`default_nettype none
package bpa_pkg;
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_VIRT  = 3'd1;
   localparam logic [2:0] ST_NO_PHYS  = 3'd2;
   localparam logic [2:0] ST_BAD_ARG  = 3'd3;
   localparam logic [2:0] ST_UNMAPPED = 3'd4;
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;
   localparam int SIZE_W = 23;
   localparam int ADDR_W = 22;
   localparam int DONE_W = 11;
   typedef logic [2:0] status_type;
endpackage
`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator_core.sv =====
// Top level of the bitmap first-fit page allocator.
// Uses bpa_pkg and bpa_ram (virtual bitmap, physical bitmap, page map).
//
//  channel | dir | tdata fields (low bit up)                       | tuser
//  req     | in  | size_bytes[22:0], start_address[44:23], pad     | kind
//  rsp     | out | status[2:0], virt_addr[24:3], pages_done[35:25], pad | -
//
// After reset a clearing pass runs over every bitmap and page-map entry, req_tready low.
// An allocate scans the virtual bitmap entry by entry, each a read then a check (one RAM
// port), then for each page scans the physical bitmap onward the same way and maps it.
// A free walks the pages, each a map read, then check and writes.
// A bad argument goes straight to the output state. A finished result moves to the output register and
// the next request is taken meanwhile; it waits only while that register is still full.
`default_nettype none
module bitmap_page_allocator_core #(
   parameter int VIRT_PAGES = 1024,
   parameter int PHYS_PAGES = 256,
   parameter int PAGE_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // size_bytes, start_address, zero pad
   input  wire logic [0:0]  req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // status, virt_addr, pages_done, zero pad
);
   import bpa_pkg::*;
   localparam int VW = $clog2(VIRT_PAGES);
   localparam int PW = $clog2(PHYS_PAGES);
   localparam int OW = $clog2(PAGE_BYTES);
   localparam int CW = (VW > PW ? VW : PW) + 1;
   localparam int NW = SIZE_W + 1;

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_VRD = 4'd2, S_VCHK = 4'd3,
      S_PRD = 4'd4, S_PCHK = 4'd5, S_MAP = 4'd6, S_FRD = 4'd7, S_FCHK = 4'd8,
      S_OUT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [NW-1:0] pages_ff, pages_in;       // page count of request
   logic [NW-1:0] run_ff, run_in;           // run length / pages done
   logic [NW-1:0] vi_ff, vi_in;             // virtual index under scan
   logic [NW-1:0] first_ff, first_in;
   logic [CW-1:0] pi_ff, pi_in;
   status_type st_ff, st_in;
   logic [ADDR_W-1:0] va_ff, va_in;
   logic [DONE_W-1:0] done_ff, done_in;
   status_type ost_ff, ost_in;
   logic [ADDR_W-1:0] ova_ff, ova_in;
   logic [DONE_W-1:0] odone_ff, odone_in;
   logic rv_ff, rv_in;

   logic v_we, p_we, m_we, v_wd, p_wd, v_rd, p_rd;
   logic [VW-1:0] v_a, m_a;
   logic [PW-1:0] p_a;
   logic [PW-1:0] m_wd, m_rd;

   bpa_ram #(.WIDTH(1), .DEPTH(VIRT_PAGES)) u_vbm (
      .clock(clock), .wr_en(v_we), .addr(v_a), .wr_data(v_wd), .rd_data(v_rd));
   bpa_ram #(.WIDTH(1), .DEPTH(PHYS_PAGES)) u_pbm (
      .clock(clock), .wr_en(p_we), .addr(p_a), .wr_data(p_wd), .rd_data(p_rd));
   bpa_ram #(.WIDTH(PW), .DEPTH(VIRT_PAGES)) u_map (
      .clock(clock), .wr_en(m_we), .addr(m_a), .wr_data(m_wd), .rd_data(m_rd));

   logic [SIZE_W-1:0] req_size;
   logic [ADDR_W-1:0] req_start;
   logic [NW-1:0] req_pages;
   logic [NW-1:0] vp_cur;
   always_comb begin
      req_size  = req_tdata[SIZE_W-1:0];
      req_start = req_tdata[SIZE_W+ADDR_W-1:SIZE_W];
      req_pages = NW'(({1'b0, req_size} + NW'(PAGE_BYTES - 1)) >> OW);
      vp_cur    = first_ff + run_ff;
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; pages_in = pages_ff;
      run_in = run_ff; vi_in = vi_ff; first_in = first_ff; pi_in = pi_ff;
      st_in = st_ff; va_in = va_ff; done_in = done_ff; rv_in = rv_ff;
      ost_in = ost_ff; ova_in = ova_ff; odone_in = odone_ff;
      v_we = 1'b0; p_we = 1'b0; m_we = 1'b0; v_wd = 1'b0; p_wd = 1'b0;
      m_wd = '0; v_a = vi_ff[VW-1:0]; p_a = pi_ff[PW-1:0]; m_a = vp_cur[VW-1:0];
      req_tready = 1'b0;
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_CLR: begin
            // entry 0 reserved, others free; map all zero
            v_a = clr_ff[VW-1:0]; p_a = clr_ff[PW-1:0]; m_a = clr_ff[VW-1:0];
            v_we = (clr_ff < CW'(VIRT_PAGES)); m_we = v_we;
            p_we = (clr_ff < CW'(PHYS_PAGES));
            v_wd = (clr_ff == '0); p_wd = (clr_ff == '0);
            clr_in = clr_ff + 1'b1;
            if (!v_we && !p_we) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pages_in = req_pages; run_in = '0;
               va_in = '0; done_in = '0; st_in = ST_OK; pi_in = CW'(1);
               if (req_size == '0) begin
                  st_in = ST_BAD_ARG; state_in = S_OUT;
               end else if (req_tuser[0] == KIND_ALLOC) begin
                  vi_in = NW'(1);
                  if (req_pages >= NW'(VIRT_PAGES)) begin
                     st_in = ST_NO_VIRT; state_in = S_OUT;
                  end else begin
                     state_in = S_VRD;
                  end
               end else if (req_start == '0) begin
                  st_in = ST_BAD_ARG; state_in = S_OUT;
               end else begin
                  first_in = NW'(req_start >> OW); state_in = S_FRD;
               end
            end
         end
         S_VRD: begin
            if (vi_ff >= NW'(VIRT_PAGES)) begin
               st_in = ST_NO_VIRT; state_in = S_OUT;
            end else begin
               state_in = S_VCHK;
            end
         end
         S_VCHK: begin
            if (v_rd) begin
               run_in = '0; vi_in = vi_ff + 1'b1; state_in = S_VRD;
            end else if (run_ff + 1'b1 == pages_ff) begin
               first_in = vi_ff + 1'b1 - pages_ff; run_in = '0; state_in = S_PRD;
            end else begin
               run_in = run_ff + 1'b1; vi_in = vi_ff + 1'b1; state_in = S_VRD;
            end
         end
         S_PRD: begin
            if (run_ff == pages_ff) begin
               va_in = ADDR_W'(first_ff << OW); done_in = DONE_W'(pages_ff);
               state_in = S_OUT;
            end else if (pi_ff >= CW'(PHYS_PAGES)) begin
               st_in = ST_NO_PHYS; done_in = DONE_W'(run_ff); state_in = S_OUT;
            end else begin
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (p_rd) begin
               pi_in = pi_ff + 1'b1; state_in = S_PRD;
            end else begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            // map one page; the physical scan resumes past this page
            m_we = 1'b1; m_wd = pi_ff[PW-1:0];
            v_a = vp_cur[VW-1:0]; v_we = 1'b1; v_wd = 1'b1;
            p_we = 1'b1; p_wd = 1'b1;
            run_in = run_ff + 1'b1; pi_in = pi_ff + 1'b1; state_in = S_PRD;
         end
         S_FRD: begin
            if (run_ff == pages_ff) begin
               done_in = DONE_W'(pages_ff); state_in = S_OUT;
            end else if (vp_cur >= NW'(VIRT_PAGES)) begin
               st_in = ST_UNMAPPED; done_in = DONE_W'(run_ff); state_in = S_OUT;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (m_rd == '0) begin
               st_in = ST_UNMAPPED; done_in = DONE_W'(run_ff); state_in = S_OUT;
            end else begin
               m_we = 1'b1; m_wd = '0;
               v_a = vp_cur[VW-1:0]; v_we = 1'b1; v_wd = 1'b0;
               p_a = m_rd; p_we = 1'b1; p_wd = 1'b0;
               run_in = run_ff + 1'b1; state_in = S_FRD;
            end
         end
         S_OUT: begin
            // hand the result over once the output register is free
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1; ost_in = st_ff; ova_in = va_ff; odone_in = done_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      pages_ff <= pages_in; run_ff <= run_in; vi_ff <= vi_in;
      first_ff <= first_in; pi_ff <= pi_in; st_ff <= st_in; va_ff <= va_in;
      done_ff <= done_in;
      ost_ff <= ost_in; ova_ff <= ova_in; odone_ff <= odone_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {4'd0, odone_ff, ova_ff, ost_ff};
endmodule
`default_nettype wire

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/bpa_checker.sv =====
// Port-level checker for the page allocator, bound to the top level.
// Uses the assertion macros header and bpa_pkg.
`default_nettype none
`include "bitmap_page_allocator_core_assert.svh"
module bpa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   import bpa_pkg::*;
   `BPA_ASSERT_NXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `BPA_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
                   rsp_tvalid && $stable(rsp_tdata))
   `BPA_ASSERT_IMP(a_status, clock, reset, rsp_tvalid, rsp_tdata[2:0] <= ST_UNMAPPED)
   `BPA_ASSERT_IMP(a_va_on_fail, clock, reset, rsp_tvalid && rsp_tdata[2:0] != ST_OK,
                   rsp_tdata[24:3] == '0)
endmodule
bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);
`default_nettype wire

// ===== bench/bitmap_page_allocator_checker.sv =====
// Scoreboard for the bitmap page allocator: watches the request and response streams,
// models both page bitmaps and the page map, and compares every response beat.
// Depends on bpa_pkg.
`timescale 1ns / 100ps
module bitmap_page_allocator_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic [0:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   output int               fail_count,
   output int               outstanding,
   output int               checked_count
);
   import bpa_pkg::*;
   localparam int NUM_VPAGES = 1024;
   localparam int NUM_PPAGES = 256;
   localparam int PAGE_SIZE  = 4096;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   vaddr;
      logic [DONE_W-1:0]   pages;
   } alloc_result_type;

   bit               virt_busy [NUM_VPAGES];
   bit               phys_busy [NUM_PPAGES];
   logic [7:0]       vmap      [NUM_VPAGES];
   alloc_result_type expected_results[$];

   function automatic int first_free_run(int npages);
      int run;
      run = 0;
      if (npages >= NUM_VPAGES) return 0;
      for (int i = 1; i < NUM_VPAGES; i++) begin
         if (virt_busy[i]) run = 0;
         else begin
            run++;
            if (run == npages) return i + 1 - npages;
         end
      end
      return 0;
   endfunction

   function automatic int lowest_free_frame();
      for (int i = 1; i < NUM_PPAGES; i++)
         if (!phys_busy[i]) return i;
      return 0;
   endfunction

   // apply one request to the page tables and return the response it should give
   function automatic alloc_result_type apply_request(logic kind, logic [SIZE_W-1:0] nbytes,
                                                      logic [ADDR_W-1:0] vstart);
      alloc_result_type r;
      int npages, first, vp, pp;
      r = '0;
      if (nbytes == 0) begin
         r.status = ST_BAD_ARG;
         return r;
      end
      npages = (int'(nbytes) + PAGE_SIZE - 1) / PAGE_SIZE;
      if (kind == KIND_ALLOC) begin
         first = first_free_run(npages);
         if (first == 0) begin
            r.status = ST_NO_VIRT;
            return r;
         end
         for (int i = 0; i < npages; i++) begin
            pp = lowest_free_frame();
            if (pp == 0) begin
               r.status = ST_NO_PHYS;
               r.pages  = DONE_W'(i);
               return r;
            end
            vmap[first + i]      = 8'(pp);
            virt_busy[first + i] = 1'b1;
            phys_busy[pp]        = 1'b1;
         end
         r.status = ST_OK;
         r.vaddr  = ADDR_W'(first * PAGE_SIZE);
         r.pages  = DONE_W'(npages);
         return r;
      end
      if (vstart == 0) begin
         r.status = ST_BAD_ARG;
         return r;
      end
      for (int i = 0; i < npages; i++) begin
         vp = int'(vstart) / PAGE_SIZE + i;
         if (vp >= NUM_VPAGES || vmap[vp] == 0) begin
            r.status = ST_UNMAPPED;
            r.pages  = DONE_W'(i);
            return r;
         end
         phys_busy[vmap[vp]] = 1'b0;
         vmap[vp]            = 8'd0;
         virt_busy[vp]       = 1'b0;
      end
      r.status = ST_OK;
      r.pages  = DONE_W'(npages);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want, got;
      if (reset) begin
         for (int i = 0; i < NUM_VPAGES; i++) begin
            virt_busy[i] = 1'b0;
            vmap[i]      = 8'd0;
         end
         for (int i = 0; i < NUM_PPAGES; i++) phys_busy[i] = 1'b0;
         virt_busy[0] = 1'b1;
         phys_busy[0] = 1'b1;
         expected_results.delete();
         fail_count    <= 0;
         outstanding   <= 0;
         checked_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[2:0];
            got.vaddr  = rsp_tdata[24:3];
            got.pages  = rsp_tdata[35:25];
            checked_count <= checked_count + 1;
            if (expected_results.size() == 0) begin
               $error("response beat with nothing expected: status %0d va %0h pages %0d",
                      got.status, got.vaddr, got.pages);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  $error("status: expected %0d, got %0d", want.status, got.status);
               if (got.vaddr !== want.vaddr)
                  $error("virt_addr: expected %0h, got %0h", want.vaddr, got.vaddr);
               if (got.pages !== want.pages)
                  $error("pages_done: expected %0d, got %0d", want.pages, got.pages);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_request(req_tuser[0], req_tdata[22:0],
                                                     req_tdata[44:23]));
         outstanding <= expected_results.size();
      end
   end
endmodule

// ===== bench/tb_bitmap_page_allocator_core.sv =====
// Stimulus and verdict for the bitmap page allocator core.
// Depends on bpa_pkg, bitmap_page_allocator_core and bitmap_page_allocator_checker.
`timescale 1ns / 100ps
module tb_bitmap_page_allocator_core;
   import bpa_pkg::*;

   localparam int PAGE_SIZE   = 4096;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int PH_FULL      = 0;
   localparam int PH_SRC_IDLE  = 1;
   localparam int PH_SNK_STALL = 2;
   localparam int PH_BOTH      = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   int          fail_count, outstanding, checked_count;
   int          phase = PH_FULL;
   int          sent_count = 0;
   int          big_allocs = 0;
   int          cycle_count = 0;
   int          live_vaddr[$];
   int          live_pages[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bitmap_page_allocator_core u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   bitmap_page_allocator_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .outstanding, .checked_count
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      case (phase)
         PH_SNK_STALL: rsp_tready <= $urandom_range(99) >= 74;
         PH_BOTH:      rsp_tready <= $urandom_range(99) >= 6;
         default:      rsp_tready <= 1'b1;
      endcase
   end

   // remember granted runs so later frees can hit live mappings
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[2:0] == ST_OK
          && rsp_tdata[24:3] != 0) begin
         live_vaddr.push_back(int'(rsp_tdata[24:3]));
         live_pages.push_back(int'(rsp_tdata[35:25]));
      end
   end

   task automatic send_request(logic kind, int nbytes, int vstart);
      int gap_pct;
      gap_pct = (phase == PH_SRC_IDLE) ? 74 : (phase == PH_BOTH) ? 6 : 0;
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, 22'(vstart), 23'(nbytes)};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic random_request();
      int pick, idx, npages;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if ($urandom_range(9) < 8) send_request(KIND_ALLOC, 0, $urandom_range(4194303));
         else send_request(KIND_ALLOC, $urandom_range(16384, 1), $urandom);
      end else if (pick < 52) begin
         send_request(KIND_ALLOC, $urandom_range(64 * PAGE_SIZE, 1), 0);
      end else if (pick < 53 && big_allocs < 3) begin
         big_allocs++;
         send_request(KIND_ALLOC, $urandom_range(4194304, 200 * PAGE_SIZE), 0);
      end else if (pick < 85 && live_vaddr.size() > 0) begin
         idx    = $urandom_range(live_vaddr.size() - 1);
         npages = live_pages[idx];
         // mostly the whole run, sometimes part of it or past its end
         if ($urandom_range(9) < 2) npages = $urandom_range(npages + 2, 1);
         send_request(KIND_FREE, npages * PAGE_SIZE - $urandom_range(PAGE_SIZE - 1),
                      live_vaddr[idx] + $urandom_range(PAGE_SIZE - 1));
         live_vaddr.delete(idx);
         live_pages.delete(idx);
      end else if (pick < 95) begin
         send_request(KIND_FREE, $urandom_range(65536, 1), $urandom_range(4194303));
      end else begin
         send_request(1'($urandom_range(1)), 0, $urandom_range(4194303));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero sizes, free at address zero, oversized runs
      send_request(KIND_ALLOC, 0, 0);
      send_request(KIND_FREE, 0, 4096);
      send_request(KIND_FREE, 4096, 0);
      send_request(KIND_ALLOC, 4194304, 0);
      send_request(KIND_ALLOC, 4194303, 4194303);
      // run out of frames part way, then free until the first hole
      send_request(KIND_ALLOC, 300 * PAGE_SIZE, 0);
      send_request(KIND_FREE, 300 * PAGE_SIZE, PAGE_SIZE);
      send_request(KIND_ALLOC, 1, 0);
      send_request(KIND_ALLOC, PAGE_SIZE + 1, 0);
      // unaligned frees, then a page already gone
      send_request(KIND_FREE, 1, 2 * PAGE_SIZE + 123);
      send_request(KIND_FREE, PAGE_SIZE, 3 * PAGE_SIZE + 4095);
      send_request(KIND_FREE, PAGE_SIZE, 3 * PAGE_SIZE);
      send_request(KIND_ALLOC, PAGE_SIZE, 0);
      send_request(KIND_FREE, 2 * PAGE_SIZE, 4194303);
      send_request(KIND_FREE, 2 * PAGE_SIZE, PAGE_SIZE);
      send_request(KIND_ALLOC, 1020 * PAGE_SIZE, 0);
      send_request(KIND_FREE, 4194304, PAGE_SIZE);
      send_request(KIND_FREE, 8191, 4194303 - 4095);

      for (int p = PH_FULL; p <= PH_BOTH; p++) begin
         phase = p;
         for (int n = 0; n < 140; n++) random_request();
         if (p == PH_FULL) begin
            // hold off until the block has drained
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      phase = PH_FULL;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("sent %0d alloc/free requests across four flow-control phases", sent_count);
      $display("checked %0d responses, %0d mismatching", checked_count, fail_count);
      if (fail_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
